### src/fsr_pkg.sv
`default_nettype none

package fsr_pkg;

    // configuration register widths and reset values
    localparam int GAIN_W = 10;
    localparam int SPD_W  = 8;
    localparam int BAND_W = 9;
    localparam int INTEG_W = 16;
    localparam int HALL_W = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 10'd166;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 10'd38;
    localparam logic [SPD_W-1:0]  MIN_TARGET_RST = 8'd30;
    localparam logic [SPD_W-1:0]  MIN_DUTY_RST   = 8'd10;

    // band shaping
    localparam logic [SPD_W-1:0]  TGT_HIGH_LIMIT = 8'd240;
    localparam logic [SPD_W-1:0]  TGT_LOW_LIMIT  = 8'd35;
    localparam logic [SPD_W-1:0]  HIGH_MARGIN    = 8'd32;
    localparam logic [BAND_W-1:0] BAND_LOW_RST   = 9'd3;

    localparam logic [SPD_W-1:0]  DUTY_MAX = 8'd255;
    localparam logic [SPD_W-1:0]  SPEED_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_MIN_TARGET = 2'd2,
        CFG_MIN_DUTY   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain_q8;
        logic [GAIN_W-1:0] integ_gain_q8;
        logic [SPD_W-1:0]  min_target;
        logic [SPD_W-1:0]  min_duty;
    } t_cfg;

    typedef struct packed {
        logic              mode;
        logic [SPD_W-1:0]  requested_speed;
        logic [HALL_W-1:0] hall_edges;
    } t_in_item;

    typedef struct packed {
        logic [SPD_W-1:0] duty_out;
        logic             duty_written;
        logic [SPD_W-1:0] speed_now;
        logic             request_too_low;
        logic             rotor_locked;
        logic             regulating;
    } t_result;

    // x / 5 by reciprocal, exact for x below 64
    function automatic logic [3:0] div5(input logic [5:0] x);
        logic [13:0] p;
        p = {8'd0, x} * 14'd205;
        return p[13:10];
    endfunction

endpackage

`default_nettype wire

### src/fsr_cfg_regs.sv
`default_nettype none

module fsr_cfg_regs
    import fsr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [GAIN_W-1:0]    i_cfg_wdata,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain_q8  <= PROP_GAIN_RST;
            r_cfg.integ_gain_q8 <= INTEG_GAIN_RST;
            r_cfg.min_target    <= MIN_TARGET_RST;
            r_cfg.min_duty      <= MIN_DUTY_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PROP_GAIN:  r_cfg.prop_gain_q8  <= i_cfg_wdata;
                CFG_INTEG_GAIN: r_cfg.integ_gain_q8 <= i_cfg_wdata;
                CFG_MIN_TARGET: r_cfg.min_target    <= i_cfg_wdata[SPD_W-1:0];
                CFG_MIN_DUTY:   r_cfg.min_duty      <= i_cfg_wdata[SPD_W-1:0];
                default:        r_cfg.min_duty      <= r_cfg.min_duty;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### src/fsr_pi.sv
`default_nettype none

module fsr_pi
    import fsr_pkg::*;
(
    input  wire t_cfg                i_cfg,
    input  wire logic [SPD_W-1:0]    i_target,
    input  wire logic [SPD_W-1:0]    i_speed,
    input  wire logic [INTEG_W-1:0]  i_integ,
    output logic      [INTEG_W-1:0]  o_integ,
    output logic      [SPD_W-1:0]    o_duty
);

    logic signed [9:0]  err;
    logic signed [20:0] p_term;
    logic signed [26:0] i_term;
    logic signed [27:0] sum;
    logic signed [27:0] floor_q8;

    // error fits 9 bits signed, one spare bit
    assign err     = $signed({2'b00, i_target}) - $signed({2'b00, i_speed});
    assign o_integ = i_integ + {{(INTEG_W-10){err[9]}}, err};

    assign p_term = $signed({1'b0, i_cfg.prop_gain_q8}) * err;
    assign i_term = $signed({1'b0, i_cfg.integ_gain_q8}) * $signed(o_integ);
    assign sum    = {{7{p_term[20]}}, p_term} + {i_term[26], i_term};

    assign floor_q8 = $signed({12'd0, i_cfg.min_duty, 8'd0});

    always_comb begin
        priority if (sum > 28'sd65280) begin
            o_duty = DUTY_MAX;
        end else if (sum <= floor_q8) begin
            o_duty = i_cfg.min_duty;
        end else begin
            o_duty = sum[15:8];
        end
    end

endmodule

`default_nettype wire

### src/fsr_core.sv
`default_nettype none

module fsr_core
    import fsr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_cfg     i_cfg,
    input  wire t_in_item i_item,
    output t_result       o_result
);

    logic [SPD_W-1:0]   r_target,   n_target;
    logic [BAND_W-1:0]  r_band_lo,  n_band_lo;
    logic [BAND_W-1:0]  r_band_hi,  n_band_hi;
    logic [SPD_W-1:0]   r_mrg_lo,   n_mrg_lo;
    logic [SPD_W-1:0]   r_mrg_hi,   n_mrg_hi;
    logic [INTEG_W-1:0] r_integ,    n_integ;
    logic [1:0]         r_stall,    n_stall;
    logic [SPD_W-1:0]   r_speed,    n_speed;
    logic [SPD_W-1:0]   r_duty,     n_duty;
    logic               r_active,   n_active;
    logic               r_low_req,  n_low_req;

    logic [SPD_W-1:0]   tgt_sel;
    logic [SPD_W-1:0]   eff_tgt;
    logic [3:0]         m20;
    logic [SPD_W-1:0]   new_mrg_lo;
    logic [SPD_W-1:0]   new_mrg_hi;
    logic [BAND_W-1:0]  new_band_lo;
    logic [BAND_W-1:0]  new_band_hi;
    logic [10:0]        speed_raw;
    logic [SPD_W-1:0]   meas;
    logic [SPD_W-1:0]   speed_next;
    logic               arm;
    logic [BAND_W-1:0]  wide_dec;
    logic [BAND_W-1:0]  wide_lo;
    logic [BAND_W-1:0]  wide_hi;
    logic               restart;
    logic               do_start;
    logic [INTEG_W-1:0] pi_integ;
    logic [SPD_W-1:0]   pi_duty;
    logic [1:0]         stall_inc;
    logic               stalled;
    logic               locked;
    logic               written;

    // a restart reuses the stored target
    assign tgt_sel = i_item.mode ? r_target : i_item.requested_speed;
    assign eff_tgt = (tgt_sel != '0 && tgt_sel < i_cfg.min_target) ? i_cfg.min_target
                                                                 : tgt_sel;

    assign m20 = div5(eff_tgt[7:2]);
    always_comb begin
        priority if (eff_tgt > TGT_HIGH_LIMIT) begin
            new_mrg_lo = HIGH_MARGIN;
            new_mrg_hi = '0;
        end else if (eff_tgt < TGT_LOW_LIMIT) begin
            new_mrg_lo = {4'd0, m20};
            new_mrg_hi = {4'd0, div5(eff_tgt[5:0])};
        end else begin
            new_mrg_lo = {4'd0, m20};
            new_mrg_hi = {4'd0, m20};
        end
    end
    assign new_band_lo = {1'b0, eff_tgt} - {1'b0, new_mrg_lo};
    assign new_band_hi = {1'b0, eff_tgt} + {1'b0, new_mrg_hi};

    // hall edge count to rpm/10
    assign speed_raw  = {3'd0, i_item.hall_edges[HALL_W-1:2]} * 11'd6;
    assign meas       = (speed_raw > {3'd0, SPEED_MAX}) ? SPEED_MAX : speed_raw[SPD_W-1:0];
    assign speed_next = i_item.mode ? meas : r_speed;

    assign arm = ({1'b0, speed_next} < new_band_lo) || ({1'b0, speed_next} > new_band_hi);

    // wider band for the idle check; stored low margin never exceeds 32
    assign wide_dec = {1'b0, r_mrg_lo} + {5'd0, div5(r_mrg_lo[5:0])};
    assign wide_lo  = (r_band_lo > wide_dec) ? r_band_lo - wide_dec : '0;
    assign wide_hi  = r_band_hi + {1'b0, r_mrg_hi};

    assign restart  = i_item.mode && !r_active &&
                      (({1'b0, meas} < wide_lo) || ({1'b0, meas} > wide_hi));
    assign do_start = !i_item.mode || restart;

    fsr_pi u_pi (
        .i_cfg    (i_cfg),
        .i_target (eff_tgt),
        .i_speed  (meas),
        .i_integ  (r_integ),
        .o_integ  (pi_integ),
        .o_duty   (pi_duty)
    );

    assign stall_inc = r_stall + 2'd1;
    assign stalled   = (pi_duty != '0) && (meas == '0);

    always_comb begin
        n_target  = r_target;
        n_band_lo = r_band_lo;
        n_band_hi = r_band_hi;
        n_mrg_lo  = r_mrg_lo;
        n_mrg_hi  = r_mrg_hi;
        n_integ   = r_integ;
        n_stall   = r_stall;
        n_speed   = speed_next;
        n_duty    = r_duty;
        n_active  = r_active;
        n_low_req = r_low_req;
        written   = 1'b0;
        locked    = 1'b0;

        if (do_start) begin
            n_target = tgt_sel;
            n_integ  = '0;
            n_stall  = '0;
            if (tgt_sel == '0) begin
                n_duty   = '0;
                n_active = 1'b0;
                written  = 1'b1;
            end else begin
                n_low_req = (tgt_sel < i_cfg.min_target);
                n_mrg_lo  = new_mrg_lo;
                n_mrg_hi  = new_mrg_hi;
                n_band_lo = new_band_lo;
                n_band_hi = new_band_hi;
                n_active  = arm;
            end
        end else if (r_active) begin
            // measurement while regulating
            n_integ = pi_integ;
            if (stalled) begin
                n_stall = stall_inc;
                locked  = (stall_inc > 2'd1);
            end
            if (locked) begin
                n_active = 1'b0;
            end else begin
                n_duty   = pi_duty;
                written  = 1'b1;
                n_active = ({1'b0, meas} < r_band_lo) || ({1'b0, meas} > r_band_hi);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_band_lo <= BAND_LOW_RST;
            r_band_hi <= '0;
            r_mrg_lo  <= '0;
            r_mrg_hi  <= '0;
            r_integ   <= '0;
            r_stall   <= '0;
            r_speed   <= '0;
            r_duty    <= '0;
            r_active  <= 1'b0;
            r_low_req <= 1'b0;
        end else if (i_step) begin
            r_target  <= n_target;
            r_band_lo <= n_band_lo;
            r_band_hi <= n_band_hi;
            r_mrg_lo  <= n_mrg_lo;
            r_mrg_hi  <= n_mrg_hi;
            r_integ   <= n_integ;
            r_stall   <= n_stall;
            r_speed   <= n_speed;
            r_duty    <= n_duty;
            r_active  <= n_active;
            r_low_req <= n_low_req;
        end
    end

    assign o_result.duty_out        = n_duty;
    assign o_result.duty_written    = written;
    assign o_result.speed_now       = n_speed;
    assign o_result.request_too_low = n_low_req;
    assign o_result.rotor_locked    = locked;
    assign o_result.regulating      = n_active;

endmodule

`default_nettype wire

### src/fan_speed_pi_regulator_unit.sv
// channel   | dir | payload                                       | handshake
// s_axis    | in  | tuser: mode; tdata: requested_speed, hall_edges | tvalid/tready
// m_axis    | out | tdata: duty, written, speed, flags             | tvalid/tready
// cfg write | in  | i_cfg_index selects register, i_cfg_wdata      | i_cfg_we, no wait
//
// one item per clock while m_axis_tready holds; input register, then result register
// the regulator state updates in the cycle the item moves to the result register
// synchronous active-low reset clears both valid flags, resets the state and all config
// a stalled result register holds; the input register still takes one item behind it
`default_nettype none

module fan_speed_pi_regulator_unit
    import fsr_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // slave side
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [23:0]          s_axis_tdata,   // requested_speed[7:0], hall_edges[17:8]
    input  wire logic                 s_axis_tuser,   // mode
    // master side
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [23:0]          m_axis_tdata,   // duty_out[7:0], duty_written[8],
                                                      // speed_now[16:9], request_too_low[17],
                                                      // rotor_locked[18], regulating[19]
    // configuration writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [GAIN_W-1:0]    i_cfg_wdata
);

    t_cfg     cfg;
    t_in_item r_in;
    logic     r_in_valid;
    t_result  result;
    t_result  r_out;
    logic     r_out_valid;
    logic     step;

    fsr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // item leaves the input register when the result register is free or draining
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.mode            <= s_axis_tuser;
            r_in.requested_speed <= s_axis_tdata[7:0];
            r_in.hall_edges      <= s_axis_tdata[17:8];
        end
    end

    fsr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.regulating, r_out.rotor_locked,
                            r_out.request_too_low, r_out.speed_now,
                            r_out.duty_written, r_out.duty_out};

endmodule

`default_nettype wire

### src/fsr_checker.sv
`default_nettype none

module fsr_checker
    import fsr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an aborted update neither writes duty nor keeps regulating
    a_lock_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[18] |-> !m_axis_tdata[8] && !m_axis_tdata[19])
        else $error("locked rotor item wrote duty or stayed active");

    // locked rotor only at zero speed
    a_lock_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[16:9] == 8'd0)
        else $error("locked rotor with nonzero speed");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind fan_speed_pi_regulator_unit fsr_checker u_fsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
